// ===== rtl/llpg_pkg.sv =====
// ----------------------------------------------------------------------------
// Layered LED pattern generator package
// Shared request and result types, command, layer and pattern codes, and the
// timing constants of the LED patterns.
// ----------------------------------------------------------------------------
package llpg_pkg;

	localparam int unsigned TICK_MS           = 25;
	localparam int unsigned BREATHE_PERIOD_MS = 4000;
	localparam int unsigned PULSE_PERIOD_MS   = 2000;
	localparam int unsigned SWEEP_CYCLE_MS    = 1200;
	localparam int unsigned FAST_HALF_MS      = 250;
	localparam int unsigned RAPID_PULSE_MS    = 120;
	localparam int unsigned GREEN_HALF_MS     = 120;
	localparam int unsigned RED_HALF_MS       = 150;
	localparam int unsigned SLOW_LIT_MS       = 350;
	localparam int unsigned SLOW_DARK_MS      = 650;
	localparam int unsigned FILL_SPAN         = 84;
	localparam int unsigned CHASE_SPAN        = 74;
	localparam int unsigned FILL_MAX          = 100;

	localparam int unsigned QUEUE_DEPTH = 2;

	// Periods of the phase counters that track elapsed milliseconds.
	localparam int unsigned P_BREATHE = BREATHE_PERIOD_MS;
	localparam int unsigned P_PULSE   = PULSE_PERIOD_MS;
	localparam int unsigned P_COUNT   = SLOW_LIT_MS + SLOW_DARK_MS;
	localparam int unsigned P_RAPID   = 2 * RAPID_PULSE_MS;
	localparam int unsigned P_GREEN   = 2 * GREEN_HALF_MS;
	localparam int unsigned P_RED     = 2 * RED_HALF_MS;
	localparam int unsigned P_CHASE   = SWEEP_CYCLE_MS;
	localparam int unsigned P_FAST    = 2 * FAST_HALF_MS;

	localparam int unsigned W_BREATHE = $clog2(P_BREATHE);
	localparam int unsigned W_PULSE   = $clog2(P_PULSE);
	localparam int unsigned W_COUNT   = $clog2(P_COUNT);
	localparam int unsigned W_RAPID   = $clog2(P_RAPID);
	localparam int unsigned W_GREEN   = $clog2(P_GREEN);
	localparam int unsigned W_RED     = $clog2(P_RED);
	localparam int unsigned W_CHASE   = $clog2(P_CHASE);
	localparam int unsigned W_FAST    = $clog2(P_FAST);

	// When the 32-bit millisecond count wraps, each phase moves by the step
	// plus the part of the period lost at the wrap.
	localparam logic [63:0] MS_RANGE = 64'h1_0000_0000;
	localparam int unsigned WS_BREATHE =
		int'((64'(P_BREATHE) + 64'(TICK_MS) - MS_RANGE % 64'(P_BREATHE)) % 64'(P_BREATHE));
	localparam int unsigned WS_PULSE =
		int'((64'(P_PULSE) + 64'(TICK_MS) - MS_RANGE % 64'(P_PULSE)) % 64'(P_PULSE));
	localparam int unsigned WS_COUNT =
		int'((64'(P_COUNT) + 64'(TICK_MS) - MS_RANGE % 64'(P_COUNT)) % 64'(P_COUNT));
	localparam int unsigned WS_RAPID =
		int'((64'(P_RAPID) + 64'(TICK_MS) - MS_RANGE % 64'(P_RAPID)) % 64'(P_RAPID));
	localparam int unsigned WS_GREEN =
		int'((64'(P_GREEN) + 64'(TICK_MS) - MS_RANGE % 64'(P_GREEN)) % 64'(P_GREEN));
	localparam int unsigned WS_RED =
		int'((64'(P_RED) + 64'(TICK_MS) - MS_RANGE % 64'(P_RED)) % 64'(P_RED));
	localparam int unsigned WS_CHASE =
		int'((64'(P_CHASE) + 64'(TICK_MS) - MS_RANGE % 64'(P_CHASE)) % 64'(P_CHASE));
	localparam int unsigned WS_FAST =
		int'((64'(P_FAST) + 64'(TICK_MS) - MS_RANGE % 64'(P_FAST)) % 64'(P_FAST));

	localparam logic [1:0] CMD_TICK = 2'd0;
	localparam logic [1:0] CMD_SET  = 2'd1;
	localparam logic [1:0] CMD_FILL = 2'd2;

	localparam logic [1:0] LAYER_BASE    = 2'd0;
	localparam logic [1:0] LAYER_UPLOAD  = 2'd1;
	localparam logic [1:0] LAYER_CAPTURE = 2'd2;

	localparam logic [3:0] PAT_OFF          = 4'd0;
	localparam logic [3:0] PAT_SOLID_WHITE  = 4'd1;
	localparam logic [3:0] PAT_DIM_BREATHE  = 4'd2;
	localparam logic [3:0] PAT_AMBER_SLOW   = 4'd3;
	localparam logic [3:0] PAT_AMBER_RAPID  = 4'd4;
	localparam logic [3:0] PAT_GREEN_FLASH  = 4'd5;
	localparam logic [3:0] PAT_GREEN_PULSE  = 4'd6;
	localparam logic [3:0] PAT_GREEN_TRIPLE = 4'd7;
	localparam logic [3:0] PAT_WHITE_FLASH  = 4'd8;
	localparam logic [3:0] PAT_BLUE_PULSE   = 4'd9;
	localparam logic [3:0] PAT_RED_TRIPLE   = 4'd10;
	localparam logic [3:0] PAT_SOLID_RED    = 4'd11;
	localparam logic [3:0] PAT_AMBER_CHASE  = 4'd12;
	localparam logic [3:0] PAT_AMBER_FAST   = 4'd13;
	localparam logic [3:0] PAT_AMBER_FILL   = 4'd14;
	localparam logic [3:0] PAT_RED_FLASH    = 4'd15;

	typedef struct packed {
		logic [1:0] command;
		logic [1:0] layer;
		logic [3:0] pattern;
		logic [7:0] fill_percent;
	} cmd_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} led_t;

	typedef struct packed {
		logic [W_BREATHE-1:0] breathe;
		logic [W_PULSE-1:0]   pulse;
		logic [W_COUNT-1:0]   count;
		logic [W_RAPID-1:0]   rapid;
		logic [W_GREEN-1:0]   green;
		logic [W_RED-1:0]     red;
		logic [W_CHASE-1:0]   chase;
		logic [W_FAST-1:0]    fast;
	} phase_t;

	typedef struct packed {
		logic [3:0] pattern;
		logic [6:0] fill;
		phase_t     ph;
	} job_t;

endpackage

// ===== rtl/llpg_front.sv =====
// ----------------------------------------------------------------------------
// Layered LED pattern generator front end
// Accepts requests, keeps the layer patterns and the elapsed-time phases, and
// turns each tick into a render job for the back end.
// ----------------------------------------------------------------------------
module llpg_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  llpg_pkg::cmd_t   cmd,
	input  logic             q_full,
	output logic             push,
	output llpg_pkg::job_t   job
);

	localparam int unsigned WB = llpg_pkg::W_BREATHE;
	localparam int unsigned WP = llpg_pkg::W_PULSE;
	localparam int unsigned WC = llpg_pkg::W_COUNT;
	localparam int unsigned WR = llpg_pkg::W_RAPID;
	localparam int unsigned WG = llpg_pkg::W_GREEN;
	localparam int unsigned WD = llpg_pkg::W_RED;
	localparam int unsigned WH = llpg_pkg::W_CHASE;
	localparam int unsigned WF = llpg_pkg::W_FAST;

	function automatic logic [15:0] step_phase(input logic [15:0] ph, input logic [15:0] period,
			input logic [15:0] wrap_step, input logic wrap);
		logic [15:0] sum;
		sum = ph + (wrap ? wrap_step : 16'(llpg_pkg::TICK_MS));
		if (sum >= period) begin
			sum = sum - period;
		end
		return sum;
	endfunction

	logic [3:0]        base_q;
	logic [3:0]        upload_q;
	logic [3:0]        capture_q;
	logic [3:0]        shown_q;
	logic              restart_q;
	logic [6:0]        fill_q;
	logic [31:0]       ms_q;
	llpg_pkg::phase_t  ph_q;

	logic              accept;
	logic              base_holds;
	logic [3:0]        win;
	logic              restart;
	logic [31:0]       ms_cur;
	logic [32:0]       ms_sum;
	logic              wrap;
	llpg_pkg::phase_t  ph_cur;
	llpg_pkg::phase_t  ph_nxt;
	logic [15:0]       s_breathe, s_pulse, s_count, s_rapid, s_green, s_red, s_chase, s_fast;

	assign accept = cmd_valid && !q_full;

	always_comb begin
		case (base_q) inside
			llpg_pkg::PAT_DIM_BREATHE, llpg_pkg::PAT_SOLID_RED, llpg_pkg::PAT_AMBER_CHASE,
			llpg_pkg::PAT_AMBER_FAST, llpg_pkg::PAT_AMBER_FILL, llpg_pkg::PAT_RED_FLASH: begin
				base_holds = 1'b1;
			end
			default: begin
				base_holds = 1'b0;
			end
		endcase
	end

	always_comb begin
		if (capture_q != llpg_pkg::PAT_OFF) begin
			win = capture_q;
		end else if (upload_q != llpg_pkg::PAT_OFF && !base_holds) begin
			win = upload_q;
		end else begin
			win = base_q;
		end
	end

	assign restart = (win != shown_q) || restart_q;
	assign ms_cur  = restart ? '0 : ms_q;
	assign ph_cur  = restart ? '0 : ph_q;
	assign ms_sum  = {1'b0, ms_cur} + 33'(llpg_pkg::TICK_MS);
	assign wrap    = ms_sum[32];

	assign s_breathe = step_phase(16'(ph_cur.breathe), 16'(llpg_pkg::P_BREATHE),
		16'(llpg_pkg::WS_BREATHE), wrap);
	assign s_pulse   = step_phase(16'(ph_cur.pulse), 16'(llpg_pkg::P_PULSE),
		16'(llpg_pkg::WS_PULSE), wrap);
	assign s_count   = step_phase(16'(ph_cur.count), 16'(llpg_pkg::P_COUNT),
		16'(llpg_pkg::WS_COUNT), wrap);
	assign s_rapid   = step_phase(16'(ph_cur.rapid), 16'(llpg_pkg::P_RAPID),
		16'(llpg_pkg::WS_RAPID), wrap);
	assign s_green   = step_phase(16'(ph_cur.green), 16'(llpg_pkg::P_GREEN),
		16'(llpg_pkg::WS_GREEN), wrap);
	assign s_red     = step_phase(16'(ph_cur.red), 16'(llpg_pkg::P_RED),
		16'(llpg_pkg::WS_RED), wrap);
	assign s_chase   = step_phase(16'(ph_cur.chase), 16'(llpg_pkg::P_CHASE),
		16'(llpg_pkg::WS_CHASE), wrap);
	assign s_fast    = step_phase(16'(ph_cur.fast), 16'(llpg_pkg::P_FAST),
		16'(llpg_pkg::WS_FAST), wrap);

	always_comb begin
		ph_nxt.breathe = s_breathe[WB-1:0];
		ph_nxt.pulse   = s_pulse[WP-1:0];
		ph_nxt.count   = s_count[WC-1:0];
		ph_nxt.rapid   = s_rapid[WR-1:0];
		ph_nxt.green   = s_green[WG-1:0];
		ph_nxt.red     = s_red[WD-1:0];
		ph_nxt.chase   = s_chase[WH-1:0];
		ph_nxt.fast    = s_fast[WF-1:0];
	end

	assign push        = accept && (cmd.command == llpg_pkg::CMD_TICK);
	assign job.pattern = win;
	assign job.fill    = fill_q;
	assign job.ph      = ph_cur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= llpg_pkg::PAT_OFF;
			upload_q  <= llpg_pkg::PAT_OFF;
			capture_q <= llpg_pkg::PAT_OFF;
			shown_q   <= llpg_pkg::PAT_OFF;
			restart_q <= 1'b0;
			fill_q    <= '0;
			ms_q      <= '0;
			ph_q      <= '0;
		end else if (accept) begin
			unique case (cmd.command)
				llpg_pkg::CMD_SET: begin
					case (cmd.layer)
						llpg_pkg::LAYER_CAPTURE: capture_q <= cmd.pattern;
						llpg_pkg::LAYER_UPLOAD:  upload_q  <= cmd.pattern;
						default:                 base_q    <= cmd.pattern;
					endcase
					restart_q <= 1'b1;
				end
				llpg_pkg::CMD_FILL: begin
					fill_q <= (cmd.fill_percent > 8'(llpg_pkg::FILL_MAX)) ?
						7'(llpg_pkg::FILL_MAX) : cmd.fill_percent[6:0];
					base_q <= llpg_pkg::PAT_AMBER_FILL;
				end
				llpg_pkg::CMD_TICK: begin
					shown_q   <= win;
					restart_q <= 1'b0;
					ms_q      <= ms_sum[31:0];
					ph_q      <= ph_nxt;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== rtl/llpg_queue.sv =====
// ----------------------------------------------------------------------------
// Layered LED pattern generator job queue
// A short first-in first-out buffer of render jobs between the front end
// and the back end.
// ----------------------------------------------------------------------------
module llpg_queue #(
	parameter int unsigned DEPTH = llpg_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  llpg_pkg::job_t  push_data,
	output logic            full,
	input  logic            pop,
	output llpg_pkg::job_t  pop_data,
	output logic            avail
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	llpg_pkg::job_t    entries_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign avail    = (count_q != '0);
	assign pop_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/llpg_back.sv =====
// ----------------------------------------------------------------------------
// Layered LED pattern generator back end
// Renders the color of one job from its pattern and phases and holds it in
// the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module llpg_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            job_avail,
	input  llpg_pkg::job_t  job,
	output logic            pop,
	output logic            led_valid,
	input  logic            led_stall,
	output llpg_pkg::led_t  led
);

	localparam int unsigned WB = llpg_pkg::W_BREATHE;
	localparam int unsigned WP = llpg_pkg::W_PULSE;
	localparam int unsigned WC = llpg_pkg::W_COUNT;
	localparam int unsigned WR = llpg_pkg::W_RAPID;
	localparam int unsigned WG = llpg_pkg::W_GREEN;
	localparam int unsigned WD = llpg_pkg::W_RED;
	localparam int unsigned WH = llpg_pkg::W_CHASE;
	localparam int unsigned WF = llpg_pkg::W_FAST;

	// Scaled divisions by reciprocal multiplication. The fractions are the
	// reduced forms of 12/2000, 60/1000, 50/1000, 74/1200 and 84/100; each
	// shift is chosen so that the truncated quotient is exact over the range.
	localparam int unsigned BR_NUM = 3;
	localparam int unsigned BR_DEN = 500;
	localparam int unsigned BR_SHIFT = 24;
	localparam int unsigned BR_MUL = BR_NUM * ((2**BR_SHIFT + BR_DEN - 1) / BR_DEN);
	localparam int unsigned GP_NUM = 3;
	localparam int unsigned GP_DEN = 50;
	localparam int unsigned GP_SHIFT = 16;
	localparam int unsigned GP_MUL = GP_NUM * ((2**GP_SHIFT + GP_DEN - 1) / GP_DEN);
	localparam int unsigned BP_NUM = 1;
	localparam int unsigned BP_DEN = 20;
	localparam int unsigned BP_SHIFT = 16;
	localparam int unsigned BP_MUL = BP_NUM * ((2**BP_SHIFT + BP_DEN - 1) / BP_DEN);
	localparam int unsigned CH_NUM = 37;
	localparam int unsigned CH_DEN = 600;
	localparam int unsigned CH_SHIFT = 26;
	localparam int unsigned CH_MUL = CH_NUM * ((2**CH_SHIFT + CH_DEN - 1) / CH_DEN);
	localparam int unsigned FL_NUM = 21;
	localparam int unsigned FL_DEN = 25;
	localparam int unsigned FL_SHIFT = 16;
	localparam int unsigned FL_MUL = FL_NUM * ((2**FL_SHIFT + FL_DEN - 1) / FL_DEN);

	localparam int unsigned BR_PW = WB + $clog2(BR_MUL + 1);
	localparam int unsigned GP_PW = WP + $clog2(GP_MUL + 1);
	localparam int unsigned BP_PW = WP + $clog2(BP_MUL + 1);
	localparam int unsigned CH_PW = WH + $clog2(CH_MUL + 1);
	localparam int unsigned FL_PW = 7 + $clog2(FL_MUL + 1);

	logic [WB-1:0]     up_br;
	logic [WP-1:0]     up_pu;
	logic [BR_PW-1:0]  prod_br;
	logic [GP_PW-1:0]  prod_gp;
	logic [BP_PW-1:0]  prod_bp;
	logic [CH_PW-1:0]  prod_ch;
	logic [FL_PW-1:0]  prod_fl;
	logic [7:0]        lvl_br, lvl_gp, lvl_bp, lvl_ch, lvl_fl;
	llpg_pkg::led_t    color;
	logic              led_valid_q;
	llpg_pkg::led_t    led_q;

	assign up_br = (job.ph.breathe < WB'(llpg_pkg::P_BREATHE / 2)) ?
		job.ph.breathe : WB'(llpg_pkg::P_BREATHE) - job.ph.breathe;
	assign up_pu = (job.ph.pulse < WP'(llpg_pkg::P_PULSE / 2)) ?
		job.ph.pulse : WP'(llpg_pkg::P_PULSE) - job.ph.pulse;

	assign prod_br = BR_PW'(up_br) * BR_PW'(BR_MUL);
	assign prod_gp = GP_PW'(up_pu) * GP_PW'(GP_MUL);
	assign prod_bp = BP_PW'(up_pu) * BP_PW'(BP_MUL);
	assign prod_ch = CH_PW'(job.ph.chase) * CH_PW'(CH_MUL);
	assign prod_fl = FL_PW'(job.fill) * FL_PW'(FL_MUL);

	assign lvl_br = 8'(prod_br >> BR_SHIFT) + 8'd2;
	assign lvl_gp = 8'(prod_gp >> GP_SHIFT) + 8'd6;
	assign lvl_bp = 8'(prod_bp >> BP_SHIFT) + 8'd10;
	assign lvl_ch = 8'(prod_ch >> CH_SHIFT) + 8'd6;
	assign lvl_fl = 8'(prod_fl >> FL_SHIFT) + 8'd6;

	always_comb begin
		color = '0;
		unique case (job.pattern)
			llpg_pkg::PAT_SOLID_WHITE: begin
				color = '{red: 8'd12, green: 8'd12, blue: 8'd12};
			end
			llpg_pkg::PAT_DIM_BREATHE: begin
				color = '{red: lvl_br, green: lvl_br, blue: lvl_br};
			end
			llpg_pkg::PAT_AMBER_SLOW: begin
				if (job.ph.count < WC'(llpg_pkg::SLOW_LIT_MS)) begin
					color = '{red: 8'd80, green: 8'd40, blue: 8'd0};
				end
			end
			llpg_pkg::PAT_AMBER_RAPID: begin
				if (job.ph.rapid >= WR'(llpg_pkg::RAPID_PULSE_MS)) begin
					color = '{red: 8'd80, green: 8'd40, blue: 8'd0};
				end
			end
			llpg_pkg::PAT_GREEN_FLASH: begin
				color.green = 8'd90;
			end
			llpg_pkg::PAT_GREEN_PULSE: begin
				color.green = lvl_gp;
			end
			llpg_pkg::PAT_GREEN_TRIPLE: begin
				if (job.ph.green < WG'(llpg_pkg::GREEN_HALF_MS)) begin
					color.green = 8'd100;
				end
			end
			llpg_pkg::PAT_WHITE_FLASH: begin
				color = '{red: 8'd120, green: 8'd120, blue: 8'd120};
			end
			llpg_pkg::PAT_BLUE_PULSE: begin
				color.blue = lvl_bp;
			end
			llpg_pkg::PAT_RED_TRIPLE: begin
				if (job.ph.red < WD'(llpg_pkg::RED_HALF_MS)) begin
					color.red = 8'd90;
				end
			end
			llpg_pkg::PAT_SOLID_RED: begin
				color.red = 8'd64;
			end
			llpg_pkg::PAT_AMBER_CHASE: begin
				color = '{red: lvl_ch, green: lvl_ch >> 1, blue: 8'd0};
			end
			llpg_pkg::PAT_AMBER_FAST: begin
				if (job.ph.fast < WF'(llpg_pkg::FAST_HALF_MS)) begin
					color = '{red: 8'd90, green: 8'd45, blue: 8'd0};
				end else begin
					color = '{red: 8'd6, green: 8'd3, blue: 8'd0};
				end
			end
			llpg_pkg::PAT_AMBER_FILL: begin
				color = '{red: lvl_fl, green: lvl_fl >> 1, blue: 8'd0};
			end
			llpg_pkg::PAT_RED_FLASH: begin
				color.red = 8'd110;
			end
			default: begin
				color = '0;
			end
		endcase
	end

	assign pop       = job_avail && (!led_valid_q || !led_stall);
	assign led_valid = led_valid_q;
	assign led       = led_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			led_q <= color;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_valid_q <= 1'b0;
		end else if (pop) begin
			led_valid_q <= 1'b1;
		end else if (!led_stall) begin
			led_valid_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/layered_led_pattern_generator_top.sv =====
// ----------------------------------------------------------------------------
// Layered LED pattern generator
// Drives one RGB LED from base, upload and capture pattern layers.
// ----------------------------------------------------------------------------
// The cmd channel carries requests: a set request writes one layer's pattern,
// a fill request sets the amber fill level, and a tick request renders the
// winning layer for the next 25 ms step. Only a tick produces a result, which
// leaves on the led channel as one red, green and blue triple.
// A request is taken whenever cmd_stall is low, so the block sustains one
// request per clock while cmd_stall stays low. A tick accepted while the
// queue and the output register are empty passes through the queue into the
// output register, from which it shows on led. The job queue lies between
// the front end and the output register of the renderer; the phase steps
// and the reciprocal multiplications are combinational.
// Reset clears all layers to off, the fill level and the elapsed time to
// zero, and empties the queue and the output register.
// While led_stall is high the result holds; the queue absorbs further ticks
// and cmd_stall rises once it is full.
// ----------------------------------------------------------------------------
module layered_led_pattern_generator_top #(
	parameter int unsigned QUEUE_DEPTH = llpg_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_stall,
	input  llpg_pkg::cmd_t  cmd,
	output logic            led_valid,
	input  logic            led_stall,
	output llpg_pkg::led_t  led
);

	logic            push;
	logic            q_full;
	logic            pop;
	logic            avail;
	llpg_pkg::job_t  push_job;
	llpg_pkg::job_t  pop_job;

	assign cmd_stall = q_full;

	llpg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.q_full    (q_full),
		.push      (push),
		.job       (push_job)
	);

	llpg_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_job),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_job),
		.avail     (avail)
	);

	llpg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_avail (avail),
		.job       (pop_job),
		.pop       (pop),
		.led_valid (led_valid),
		.led_stall (led_stall),
		.led       (led)
	);

endmodule

// ===== rtl/llpg_checker.sv =====
// ----------------------------------------------------------------------------
// Layered LED pattern generator checker
// Port-level properties of the generator, bound to its top level.
// ----------------------------------------------------------------------------
module llpg_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            cmd_valid,
	input logic            cmd_stall,
	input llpg_pkg::cmd_t  cmd,
	input logic            led_valid,
	input logic            led_stall,
	input llpg_pkg::led_t  led
);

	a_led_hold: assert property (@(posedge clk) disable iff (!arst_n)
		led_valid && led_stall |=> led_valid && $stable(led))
		else $error("led result changed while stalled");

	a_tick_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall && cmd.command == llpg_pkg::CMD_TICK |=> ##1 led_valid)
		else $error("accepted tick produced no result");

	a_empty_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!led_valid |-> !cmd_stall)
		else $error("request stalled with an empty output");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		led_valid |-> led.red <= 8'd120 && led.green <= 8'd120 && led.blue <= 8'd120)
		else $error("LED level out of range");

endmodule

bind layered_led_pattern_generator_top llpg_checker u_llpg_checker (.*);

// ===== tb/sv/tb_layered_led_pattern_generator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Layered LED pattern generator testbench
// Sends set, fill, tick and unused requests to the block with random gaps and
// random result stalls. It keeps its own model of the three layers, the tick
// count and the fill level, predicts the color of every tick and compares
// each result with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_layered_led_pattern_generator_top;

	localparam logic [1:0] CMD_UNUSED   = 2'd3;
	localparam logic [1:0] LAYER_UNUSED = 2'd3;

	logic            clk;
	logic            arst_n;
	logic            cmd_valid;
	logic            cmd_stall;
	llpg_pkg::cmd_t  cmd;
	logic            led_valid;
	logic            led_stall;
	llpg_pkg::led_t  led;

	llpg_pkg::led_t  led_expect[$];
	int unsigned     failures;
	bit              no_idle;

	logic [3:0]  base_pat;
	logic [3:0]  upload_pat;
	logic [3:0]  capture_pat;
	logic [3:0]  shown_pat;
	logic        restart_due;
	logic [31:0] tick_cnt;
	logic [6:0]  fill_lvl;

	layered_led_pattern_generator_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.led_valid (led_valid),
		.led_stall (led_stall),
		.led       (led)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int unsigned draw_wait();
		return no_idle ? 0 : $urandom_range(0, 6);
	endfunction

	function automatic llpg_pkg::cmd_t make_request(input logic [1:0] op,
			input logic [1:0] lay, input logic [3:0] pat, input logic [7:0] pct);
		llpg_pkg::cmd_t r;
		r.command      = op;
		r.layer        = lay;
		r.pattern      = pat;
		r.fill_percent = pct;
		return r;
	endfunction

	function automatic llpg_pkg::cmd_t random_request(input logic [1:0] op);
		return make_request(op, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
			8'($urandom_range(0, 255)));
	endfunction

	function automatic bit base_overrides(input logic [3:0] pat);
		return pat == llpg_pkg::PAT_DIM_BREATHE || pat == llpg_pkg::PAT_SOLID_RED ||
			pat == llpg_pkg::PAT_AMBER_CHASE || pat == llpg_pkg::PAT_AMBER_FAST ||
			pat == llpg_pkg::PAT_AMBER_FILL || pat == llpg_pkg::PAT_RED_FLASH;
	endfunction

	function automatic logic [3:0] winning_pattern();
		if (capture_pat != llpg_pkg::PAT_OFF)
			return capture_pat;
		if (upload_pat != llpg_pkg::PAT_OFF && !base_overrides(base_pat))
			return upload_pat;
		return base_pat;
	endfunction

	function automatic llpg_pkg::led_t led_colour(input logic [3:0] pat,
			input logic [31:0] ticks, input logic [6:0] level);
		logic [31:0]     ms;
		logic [31:0]     ph;
		logic [31:0]     up;
		logic [31:0]     v;
		llpg_pkg::led_t  c;
		ms = ticks * llpg_pkg::TICK_MS;
		c  = '0;
		case (pat)
		llpg_pkg::PAT_SOLID_WHITE: begin
			c.red = 8'd12; c.green = 8'd12; c.blue = 8'd12;
		end
		llpg_pkg::PAT_DIM_BREATHE: begin
			ph = ms % llpg_pkg::BREATHE_PERIOD_MS;
			up = (ph < llpg_pkg::BREATHE_PERIOD_MS / 2) ? ph :
				llpg_pkg::BREATHE_PERIOD_MS - ph;
			v  = 2 + (up * 12) / (llpg_pkg::BREATHE_PERIOD_MS / 2);
			c.red = v[7:0]; c.green = v[7:0]; c.blue = v[7:0];
		end
		llpg_pkg::PAT_AMBER_SLOW: begin
			if (ms % (llpg_pkg::SLOW_LIT_MS + llpg_pkg::SLOW_DARK_MS) <
					llpg_pkg::SLOW_LIT_MS) begin
				c.red = 8'd80; c.green = 8'd40;
			end
		end
		llpg_pkg::PAT_AMBER_RAPID: begin
			if ((ms / llpg_pkg::RAPID_PULSE_MS) % 2 != 0) begin
				c.red = 8'd80; c.green = 8'd40;
			end
		end
		llpg_pkg::PAT_GREEN_FLASH: c.green = 8'd90;
		llpg_pkg::PAT_GREEN_PULSE: begin
			ph = ms % llpg_pkg::PULSE_PERIOD_MS;
			up = (ph < llpg_pkg::PULSE_PERIOD_MS / 2) ? ph : llpg_pkg::PULSE_PERIOD_MS - ph;
			v  = 6 + (up * 60) / (llpg_pkg::PULSE_PERIOD_MS / 2);
			c.green = v[7:0];
		end
		llpg_pkg::PAT_GREEN_TRIPLE: begin
			if ((ms / llpg_pkg::GREEN_HALF_MS) % 2 == 0)
				c.green = 8'd100;
		end
		llpg_pkg::PAT_WHITE_FLASH: begin
			c.red = 8'd120; c.green = 8'd120; c.blue = 8'd120;
		end
		llpg_pkg::PAT_BLUE_PULSE: begin
			ph = ms % llpg_pkg::PULSE_PERIOD_MS;
			up = (ph < llpg_pkg::PULSE_PERIOD_MS / 2) ? ph : llpg_pkg::PULSE_PERIOD_MS - ph;
			v  = 10 + (up * 50) / (llpg_pkg::PULSE_PERIOD_MS / 2);
			c.blue = v[7:0];
		end
		llpg_pkg::PAT_RED_TRIPLE: begin
			if ((ms / llpg_pkg::RED_HALF_MS) % 2 == 0)
				c.red = 8'd90;
		end
		llpg_pkg::PAT_SOLID_RED: c.red = 8'd64;
		llpg_pkg::PAT_AMBER_CHASE: begin
			up = ms % llpg_pkg::SWEEP_CYCLE_MS;
			v  = 6 + (up * llpg_pkg::CHASE_SPAN) / llpg_pkg::SWEEP_CYCLE_MS;
			c.red = v[7:0]; c.green = 8'(v / 2);
		end
		llpg_pkg::PAT_AMBER_FAST: begin
			if ((ms / llpg_pkg::FAST_HALF_MS) % 2 == 0) begin
				c.red = 8'd90; c.green = 8'd45;
			end else begin
				c.red = 8'd6; c.green = 8'd3;
			end
		end
		llpg_pkg::PAT_AMBER_FILL: begin
			v = 6 + (32'(level) * llpg_pkg::FILL_SPAN) / llpg_pkg::FILL_MAX;
			c.red = v[7:0]; c.green = 8'(v / 2);
		end
		llpg_pkg::PAT_RED_FLASH: c.red = 8'd110;
		default: c = '0;
		endcase
		return c;
	endfunction

	task automatic predict_request(input llpg_pkg::cmd_t r);
		logic [3:0] now;
		case (r.command)
		llpg_pkg::CMD_SET: begin
			case (r.layer)
			llpg_pkg::LAYER_CAPTURE: capture_pat = r.pattern;
			llpg_pkg::LAYER_UPLOAD:  upload_pat = r.pattern;
			default:                 base_pat = r.pattern;
			endcase
			restart_due = 1'b1;
		end
		llpg_pkg::CMD_FILL: begin
			fill_lvl = (r.fill_percent > llpg_pkg::FILL_MAX) ? 7'(llpg_pkg::FILL_MAX) :
				r.fill_percent[6:0];
			base_pat = llpg_pkg::PAT_AMBER_FILL;
		end
		llpg_pkg::CMD_TICK: begin
			now = winning_pattern();
			if (now != shown_pat || restart_due) begin
				shown_pat   = now;
				restart_due = 1'b0;
				tick_cnt    = '0;
			end
			led_expect.push_back(led_colour(shown_pat, tick_cnt, fill_lvl));
			tick_cnt = tick_cnt + 32'd1;
		end
		default: ;
		endcase
	endtask

	task automatic send_request(input llpg_pkg::cmd_t r);
		int unsigned gap;
		gap = draw_wait();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd       <= r;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		predict_request(r);
	endtask

	task automatic hold_until_drained();
		cmd_valid <= 1'b0;
		do
			@(posedge clk);
		while (led_expect.size() != 0);
	endtask

	task automatic send_tick();
		send_request(random_request(llpg_pkg::CMD_TICK));
	endtask

	task automatic test_layer_priority();
		send_tick();
		send_request(make_request(llpg_pkg::CMD_SET, llpg_pkg::LAYER_CAPTURE,
			llpg_pkg::PAT_RED_FLASH, 8'd0));
		send_tick();
		send_tick();
		send_request(make_request(llpg_pkg::CMD_SET, llpg_pkg::LAYER_UPLOAD,
			llpg_pkg::PAT_BLUE_PULSE, 8'd255));
		send_tick();
		send_request(make_request(llpg_pkg::CMD_SET, llpg_pkg::LAYER_CAPTURE,
			llpg_pkg::PAT_OFF, 8'd0));
		send_tick();
		send_request(make_request(llpg_pkg::CMD_SET, llpg_pkg::LAYER_BASE,
			llpg_pkg::PAT_SOLID_RED, 8'd0));
		send_tick();
	endtask

	task automatic test_unused_codes();
		send_request(make_request(llpg_pkg::CMD_SET, LAYER_UNUSED, llpg_pkg::PAT_OFF,
			8'd255));
		send_tick();
		send_request(make_request(CMD_UNUSED, llpg_pkg::LAYER_CAPTURE,
			llpg_pkg::PAT_RED_FLASH, 8'd255));
		send_tick();
	endtask

	task automatic test_fill_clamp();
		send_request(make_request(llpg_pkg::CMD_FILL, llpg_pkg::LAYER_BASE,
			llpg_pkg::PAT_OFF, 8'd255));
		send_tick();
		send_request(make_request(llpg_pkg::CMD_FILL, llpg_pkg::LAYER_CAPTURE,
			llpg_pkg::PAT_RED_FLASH, 8'd0));
		send_tick();
		send_request(make_request(llpg_pkg::CMD_FILL, llpg_pkg::LAYER_UPLOAD,
			llpg_pkg::PAT_OFF, 8'd101));
		send_tick();
		send_request(make_request(llpg_pkg::CMD_FILL, llpg_pkg::LAYER_BASE,
			llpg_pkg::PAT_OFF, 8'd100));
		send_tick();
		send_request(make_request(llpg_pkg::CMD_SET, llpg_pkg::LAYER_UPLOAD,
			llpg_pkg::PAT_OFF, 8'd0));
	endtask

	task automatic test_random_sequences(input int unsigned total);
		int unsigned     sent;
		int unsigned     pick;
		int unsigned     run;
		llpg_pkg::cmd_t  r;
		sent = 0;
		while (sent < total) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				r = random_request(llpg_pkg::CMD_SET);
				if (r.layer == llpg_pkg::LAYER_CAPTURE && $urandom_range(0, 1) == 0)
					r.pattern = llpg_pkg::PAT_OFF;
				else if (r.layer == llpg_pkg::LAYER_UPLOAD && $urandom_range(0, 2) == 0)
					r.pattern = llpg_pkg::PAT_OFF;
				send_request(r);
				sent++;
			end else if (pick < 60) begin
				r = random_request(llpg_pkg::CMD_FILL);
				case ($urandom_range(0, 7))
				0: r.fill_percent = 8'd0;
				1: r.fill_percent = 8'd99;
				2: r.fill_percent = 8'd100;
				3: r.fill_percent = 8'd101;
				4: r.fill_percent = 8'd255;
				default: ;
				endcase
				send_request(r);
				sent++;
			end else if (pick < 66) begin
				send_request(random_request(CMD_UNUSED));
			end
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(0, 12);
			while (run > 0 && sent < total) begin
				send_tick();
				sent++;
				run--;
			end
		end
	endtask

	initial begin : request_driver
		failures    = 0;
		no_idle     = 1'b0;
		base_pat    = llpg_pkg::PAT_OFF;
		upload_pat  = llpg_pkg::PAT_OFF;
		capture_pat = llpg_pkg::PAT_OFF;
		shown_pat   = llpg_pkg::PAT_OFF;
		restart_due = 1'b0;
		tick_cnt    = '0;
		fill_lvl    = '0;
		arst_n      = 1'b0;
		cmd_valid   = 1'b0;
		cmd         = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_layer_priority();
		test_unused_codes();
		test_fill_clamp();
		test_random_sequences(400);
		hold_until_drained();
		no_idle = 1'b1;
		test_random_sequences(120);
		no_idle = 1'b0;
		test_random_sequences(330);

		hold_until_drained();
		repeat (10) @(posedge clk);
		if (failures == 0) begin
			$display("layered_led_pattern_generator_top: match");
		end else begin
			$display("layered_led_pattern_generator_top: mismatch");
		end
		$finish;
	end

	initial begin : led_checker
		int unsigned     hold;
		llpg_pkg::led_t  want;
		led_stall = 1'b0;
		hold      = 0;
		forever begin
			@(posedge clk);
			if (arst_n && led_valid && !led_stall) begin
				if (led_expect.size() == 0) begin
					$error("unexpected result: red %0d green %0d blue %0d",
						led.red, led.green, led.blue);
					failures++;
				end else begin
					want = led_expect.pop_front();
					if (led.red !== want.red) begin
						$error("red: expected %0d, got %0d", want.red, led.red);
						failures++;
					end
					if (led.green !== want.green) begin
						$error("green: expected %0d, got %0d", want.green, led.green);
						failures++;
					end
					if (led.blue !== want.blue) begin
						$error("blue: expected %0d, got %0d", want.blue, led.blue);
						failures++;
					end
				end
				hold = draw_wait();
			end
			if (hold > 0) begin
				led_stall <= 1'b1;
				hold--;
			end else begin
				led_stall <= 1'b0;
			end
		end
	end

	initial begin : run_limit
		#5_000_000;
		$display("layered_led_pattern_generator_top: mismatch");
		$finish;
	end

endmodule
